[design/phc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// phc_pkg: shared types and constants of the pixel hit clusterer
// Widths of the hit and result fields, store depth, register map and the
// packed request/result structs used across the design.
// ----------------------------------------------------------------------------
package phc_pkg;

    localparam int MAX_HITS = 64;
    localparam int IDX_W    = $clog2(MAX_HITS);
    localparam int CNT_W    = $clog2(MAX_HITS + 1);

    localparam int COL_W    = 6;
    localparam int ROW_W    = 7;
    localparam int RAD_W    = 3;
    localparam int SIZE_W   = 7;
    localparam int CSUM_W   = 12;
    localparam int RSUM_W   = 13;

    localparam int APB_DW   = 32;
    localparam int PADDR_W  = 2;

    localparam logic [PADDR_W-1:0] ADDR_RADIUS  = 2'd0;
    localparam logic [RAD_W-1:0]   RADIUS_RESET = 3'd2;

    localparam logic CMD_HIT = 1'b0;
    localparam logic CMD_END = 1'b1;

    typedef struct packed {
        logic             command;
        logic [COL_W-1:0] hit_column;
        logic [ROW_W-1:0] hit_row;
    } t_hit_req;

    typedef struct packed {
        logic [SIZE_W-1:0] cluster_size;
        logic [CSUM_W-1:0] column_sum;
        logic [RSUM_W-1:0] row_sum;
        logic              last_cluster;
        logic              hits_dropped;
    } t_cluster_res;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } t_hit_entry;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } t_member;

    typedef struct packed {
        logic [RAD_W-1:0] radius;
    } t_cfg;

endpackage
`default_nettype wire

[design/phc_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// phc_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module phc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

[design/phc_regs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// phc_regs: configuration register block
// APB-style port holding the adjacency radius.
// ----------------------------------------------------------------------------
module phc_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [phc_pkg::PADDR_W-1:0] paddr,
    input  wire logic [phc_pkg::APB_DW-1:0]  pwdata,
    output logic      [phc_pkg::APB_DW-1:0]  prdata,
    output logic                             pready,
    output phc_pkg::t_cfg                    o_cfg
);
    import phc_pkg::*;

    logic [RAD_W-1:0] r_radius;
    logic             w_wr;

    assign w_wr = psel && penable && pwrite && (paddr == ADDR_RADIUS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
        end else if (w_wr) begin
            r_radius <= pwdata[RAD_W-1:0];
        end
    end

    assign pready       = 1'b1;
    assign prdata       = (paddr == ADDR_RADIUS) ? APB_DW'(r_radius) : '0;
    assign o_cfg.radius = r_radius;

endmodule
`default_nettype wire

[design/phc_seq.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// phc_seq: hit intake and clustering sequencer
// Stores hits, then grows each cluster by scanning the hit store once per
// member through one shared distance-compare unit.
// ----------------------------------------------------------------------------
module phc_seq (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    input  wire phc_pkg::t_hit_req         i_request,
    output logic                           busy,
    input  wire phc_pkg::t_cfg             i_cfg,
    output logic                           o_result_valid,
    output phc_pkg::t_cluster_res          o_result,
    output logic                           o_hs_we,
    output logic [phc_pkg::IDX_W-1:0]      o_hs_waddr,
    output phc_pkg::t_hit_entry            o_hs_wdata,
    output logic                           o_hs_re,
    output logic [phc_pkg::IDX_W-1:0]      o_hs_raddr,
    input  wire phc_pkg::t_hit_entry       i_hs_rdata,
    output logic                           o_ml_we,
    output logic [phc_pkg::IDX_W-1:0]      o_ml_waddr,
    output phc_pkg::t_member               o_ml_wdata,
    output logic                           o_ml_re,
    output logic [phc_pkg::IDX_W-1:0]      o_ml_raddr,
    input  wire phc_pkg::t_member          i_ml_rdata
);
    import phc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEED,
        S_SEED_RD,
        S_M_FETCH,
        S_SCAN,
        S_SCAN_END,
        S_M_DONE,
        S_CL_DONE
    } t_state;

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_hit_count, n_hit_count;
    logic                  r_overflow, n_overflow;
    logic [MAX_HITS-1:0]   r_flags, n_flags;
    logic [IDX_W-1:0]      r_seed, n_seed;
    logic [IDX_W-1:0]      r_p, n_p;
    logic [CNT_W-1:0]      r_mcount, n_mcount;
    logic [IDX_W-1:0]      r_j, n_j;
    logic                  r_v, n_v;
    logic [IDX_W-1:0]      r_jd, n_jd;
    logic                  r_dup, n_dup;
    logic [CNT_W-1:0]      r_size, n_size;
    logic [CSUM_W-1:0]     r_csum, n_csum;
    logic [RSUM_W-1:0]     r_rsum, n_rsum;
    logic                  r_pend_valid, n_pend_valid;
    t_cluster_res          r_pend, n_pend;
    logic                  r_out_valid, n_out_valid;
    t_cluster_res          r_out, n_out;

    logic [IDX_W-1:0]      w_last_idx;
    logic [RAD_W-1:0]      w_rad;
    logic [COL_W-1:0]      w_dc;
    logic [ROW_W-1:0]      w_dr;
    logic                  w_nb;
    logic                  w_same;
    logic                  w_join;
    logic                  w_dup_hit;

    assign w_last_idx = r_hit_count[IDX_W-1:0] - IDX_W'(1);

    // Shared compare unit: current member against the hit read this cycle.
    // A radius of zero acts as one so repeated coordinates still merge.
    always_comb begin
        w_rad = (i_cfg.radius == '0) ? RAD_W'(1) : i_cfg.radius;
        w_dc  = (i_hs_rdata.col > i_ml_rdata.col) ? (i_hs_rdata.col - i_ml_rdata.col)
                                                  : (i_ml_rdata.col - i_hs_rdata.col);
        w_dr  = (i_hs_rdata.row > i_ml_rdata.row) ? (i_hs_rdata.row - i_ml_rdata.row)
                                                  : (i_ml_rdata.row - i_hs_rdata.row);
        w_nb  = (w_dc < {{(COL_W-RAD_W){1'b0}}, w_rad}) &&
                (w_dr < {{(ROW_W-RAD_W){1'b0}}, w_rad});
        w_same    = (i_hs_rdata.col == i_ml_rdata.col) && (i_hs_rdata.row == i_ml_rdata.row);
        w_join    = r_v && !r_flags[r_jd] && w_nb;
        // Count a coordinate only at its earliest copy in the store.
        w_dup_hit = r_v && (r_jd < i_ml_rdata.idx) && w_same;
    end

    always_comb begin
        n_state      = r_state;
        n_hit_count  = r_hit_count;
        n_overflow   = r_overflow;
        n_flags      = r_flags;
        n_seed       = r_seed;
        n_p          = r_p;
        n_mcount     = r_mcount;
        n_j          = r_j;
        n_v          = (r_state == S_SCAN);
        n_jd         = r_j;
        n_dup        = r_dup;
        n_size       = r_size;
        n_csum       = r_csum;
        n_rsum       = r_rsum;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_out_valid  = 1'b0;
        n_out        = r_out;

        o_hs_we      = 1'b0;
        o_hs_waddr   = r_hit_count[IDX_W-1:0];
        o_hs_wdata   = '{col: i_request.hit_column, row: i_request.hit_row};
        o_hs_re      = 1'b0;
        o_hs_raddr   = r_j;
        o_ml_we      = 1'b0;
        o_ml_waddr   = r_mcount[IDX_W-1:0];
        o_ml_wdata   = '{idx: r_jd, col: i_hs_rdata.col, row: i_hs_rdata.row};
        o_ml_re      = 1'b0;
        o_ml_raddr   = r_p;

        // Grow the cluster: push every ungrouped neighbor of the member.
        if (w_join) begin
            n_flags[r_jd] = 1'b1;
            o_ml_we       = 1'b1;
            n_mcount      = r_mcount + CNT_W'(1);
        end
        if (w_dup_hit) begin
            n_dup = 1'b1;
        end

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_request.command == CMD_HIT) begin
                        if (r_hit_count < CNT_W'(MAX_HITS)) begin
                            o_hs_we     = 1'b1;
                            n_hit_count = r_hit_count + CNT_W'(1);
                        end else begin
                            n_overflow = 1'b1;
                        end
                    end else if (r_hit_count == '0) begin
                        n_out_valid        = 1'b1;
                        n_out.cluster_size = '0;
                        n_out.column_sum   = '0;
                        n_out.row_sum      = '0;
                        n_out.last_cluster = 1'b1;
                        n_out.hits_dropped = r_overflow;
                        n_overflow         = 1'b0;
                    end else begin
                        n_seed   = w_last_idx;
                        n_mcount = '0;
                        n_state  = S_SEED;
                    end
                end
            end
            S_SEED: begin
                if (!r_flags[r_seed]) begin
                    o_hs_re         = 1'b1;
                    o_hs_raddr      = r_seed;
                    n_flags[r_seed] = 1'b1;
                    n_state         = S_SEED_RD;
                end else if (r_seed == '0) begin
                    // No seed left: release the held result as the last one.
                    n_out_valid        = 1'b1;
                    n_out              = r_pend;
                    n_out.last_cluster = 1'b1;
                    n_out.hits_dropped = r_overflow;
                    n_pend_valid       = 1'b0;
                    n_flags            = '0;
                    n_hit_count        = '0;
                    n_overflow         = 1'b0;
                    n_state            = S_IDLE;
                end else begin
                    n_seed = r_seed - IDX_W'(1);
                end
            end
            S_SEED_RD: begin
                o_ml_we    = 1'b1;
                o_ml_waddr = '0;
                o_ml_wdata = '{idx: r_seed, col: i_hs_rdata.col, row: i_hs_rdata.row};
                n_mcount   = CNT_W'(1);
                n_p        = '0;
                n_size     = '0;
                n_csum     = '0;
                n_rsum     = '0;
                n_state    = S_M_FETCH;
            end
            S_M_FETCH: begin
                o_ml_re = 1'b1;
                n_j     = '0;
                n_dup   = 1'b0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                o_hs_re = 1'b1;
                if (r_j == w_last_idx) begin
                    n_state = S_SCAN_END;
                end else begin
                    n_j = r_j + IDX_W'(1);
                end
            end
            S_SCAN_END: begin
                n_state = S_M_DONE;
            end
            S_M_DONE: begin
                if (!r_dup) begin
                    n_size = r_size + CNT_W'(1);
                    n_csum = r_csum + {{(CSUM_W-COL_W){1'b0}}, i_ml_rdata.col};
                    n_rsum = r_rsum + {{(RSUM_W-ROW_W){1'b0}}, i_ml_rdata.row};
                end
                if ((CNT_W'(r_p) + CNT_W'(1)) < r_mcount) begin
                    n_p     = r_p + IDX_W'(1);
                    n_state = S_M_FETCH;
                end else begin
                    n_state = S_CL_DONE;
                end
            end
            S_CL_DONE: begin
                // Hold each cluster back one step until we know it is not last.
                if (r_pend_valid) begin
                    n_out_valid        = 1'b1;
                    n_out              = r_pend;
                    n_out.last_cluster = 1'b0;
                    n_out.hits_dropped = r_overflow;
                end
                n_pend.cluster_size = SIZE_W'(r_size);
                n_pend.column_sum   = r_csum;
                n_pend.row_sum      = r_rsum;
                n_pend.last_cluster = 1'b0;
                n_pend.hits_dropped = r_overflow;
                n_pend_valid        = 1'b1;
                n_state             = S_SEED;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_hit_count  <= '0;
            r_overflow   <= 1'b0;
            r_flags      <= '0;
            r_v          <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_hit_count  <= n_hit_count;
            r_overflow   <= n_overflow;
            r_flags      <= n_flags;
            r_v          <= n_v;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            r_seed       <= n_seed;
            r_p          <= n_p;
            r_mcount     <= n_mcount;
            r_j          <= n_j;
            r_jd         <= n_jd;
            r_dup        <= n_dup;
            r_size       <= n_size;
            r_csum       <= n_csum;
            r_rsum       <= n_rsum;
            r_pend       <= n_pend;
            r_out        <= n_out;
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

`ifndef SYNTHESIS
    a_last_ends_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.last_cluster) |-> (r_state == S_IDLE))
        else $error("last result issued while clustering continues");

    a_mid_result_seeds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.last_cluster) |-> (r_state == S_SEED))
        else $error("intermediate result outside seed search");

    a_flags_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_flags == '0))
        else $error("grouped flags left set between events");

    a_members_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_mcount <= r_hit_count))
        else $error("member list larger than stored hits");
`endif

endmodule
`default_nettype wire

[design/pixel_hit_clusterer_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_hit_clusterer_top: pixel hit clusterer, 8-connected at the reset radius
// Stores the hits of one event and emits one size/column-sum/row-sum result
// per cluster at the end-of-event request.
// ----------------------------------------------------------------------------
// A hit request is taken without raising busy, so hits can be loaded back to
// back. An end-of-event request raises busy while the block clusters: the
// work is a seed search over the stored hits plus neighbor scans, set by the
// single read port of the hit store, which is swept once per cluster member
// through one shared distance comparator. An empty event answers in the
// next cycle, without raising busy. Each result appears on o_result for
// exactly one cycle with o_result_valid; there is no backpressure, so the
// receiver must take it then. The last result of an event carries
// last_cluster and is issued in the cycle busy falls.
module pixel_hit_clusterer_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    input  wire phc_pkg::t_hit_req           i_request,
    output logic                             busy,
    output logic                             o_result_valid,
    output phc_pkg::t_cluster_res            o_result,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [phc_pkg::PADDR_W-1:0] paddr,
    input  wire logic [phc_pkg::APB_DW-1:0]  pwdata,
    output logic      [phc_pkg::APB_DW-1:0]  prdata,
    output logic                             pready
);
    import phc_pkg::*;

    t_cfg             w_cfg;
    logic             w_hs_we;
    logic [IDX_W-1:0] w_hs_waddr;
    t_hit_entry       w_hs_wdata;
    logic             w_hs_re;
    logic [IDX_W-1:0] w_hs_raddr;
    t_hit_entry       w_hs_rdata;
    logic             w_ml_we;
    logic [IDX_W-1:0] w_ml_waddr;
    t_member          w_ml_wdata;
    logic             w_ml_re;
    logic [IDX_W-1:0] w_ml_raddr;
    t_member          w_ml_rdata;

    phc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    phc_ram #(
        .WIDTH ($bits(t_hit_entry)),
        .DEPTH (MAX_HITS)
    ) u_hit_store (
        .i_clk   (i_clk),
        .i_we    (w_hs_we),
        .i_waddr (w_hs_waddr),
        .i_wdata (w_hs_wdata),
        .i_re    (w_hs_re),
        .i_raddr (w_hs_raddr),
        .o_rdata (w_hs_rdata)
    );

    phc_ram #(
        .WIDTH ($bits(t_member)),
        .DEPTH (MAX_HITS)
    ) u_member_list (
        .i_clk   (i_clk),
        .i_we    (w_ml_we),
        .i_waddr (w_ml_waddr),
        .i_wdata (w_ml_wdata),
        .i_re    (w_ml_re),
        .i_raddr (w_ml_raddr),
        .o_rdata (w_ml_rdata)
    );

    phc_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_request      (i_request),
        .busy           (busy),
        .i_cfg          (w_cfg),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .o_hs_we        (w_hs_we),
        .o_hs_waddr     (w_hs_waddr),
        .o_hs_wdata     (w_hs_wdata),
        .o_hs_re        (w_hs_re),
        .o_hs_raddr     (w_hs_raddr),
        .i_hs_rdata     (w_hs_rdata),
        .o_ml_we        (w_ml_we),
        .o_ml_waddr     (w_ml_waddr),
        .o_ml_wdata     (w_ml_wdata),
        .o_ml_re        (w_ml_re),
        .o_ml_raddr     (w_ml_raddr),
        .i_ml_rdata     (w_ml_rdata)
    );

endmodule
`default_nettype wire
